// ===== rtl/rprt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ride peak record tracker package
// Shared types, command codes, register indexes and range limits.
// ----------------------------------------------------------------------------
package rprt_pkg;

   localparam int LEAN_W  = 15;
   localparam int ACCEL_W = 14;
   localparam int SPEED_W = 13;
   localparam int CAND_W  = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 15;
   localparam int SLOT_W = 4;
   localparam int KIND_W = 3;

   localparam logic [LEAN_W-1:0]  LEAN_HIGH  = 15'd18000;
   localparam logic [ACCEL_W-1:0] ACCEL_HIGH = 14'd16000;
   localparam logic [SPEED_W-1:0] SPEED_HIGH = 13'd5000;

   localparam logic [LEAN_W-1:0]  LEAN_MAX_RESET  = 15'd7000;
   localparam logic [ACCEL_W-1:0] ACCEL_MAX_RESET = 14'd3000;
   localparam logic [SPEED_W-1:0] SPEED_MAX_RESET = 13'd4000;

   localparam logic [SLOT_W-1:0] NUM_KINDS = 4'd5;
   localparam logic [SLOT_W-1:0] LAST_SLOT = 4'd9;

   localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACCEL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BRAKE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SPEED = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_LEAN_MIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LEAN_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_MIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_MAX = 3'd5;

   typedef enum logic [2:0] {
      CMD_ORIENT    = 3'd0,
      CMD_SPEED     = 3'd1,
      CMD_NEW_RIDE  = 3'd2,
      CMD_RESET_ALL = 3'd3,
      CMD_RESTORE   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic [LEAN_W-1:0]  lean_min;
      logic [LEAN_W-1:0]  lean_max;
      logic [ACCEL_W-1:0] accel_min;
      logic [ACCEL_W-1:0] accel_max;
      logic [SPEED_W-1:0] speed_min;
      logic [SPEED_W-1:0] speed_max;
   } cfg_type;

   typedef struct packed {
      logic [2:0]          command;
      logic signed [15:0]  roll_angle;
      logic signed [14:0]  longitudinal_g;
      logic [SPEED_W-1:0]  speed_value;
      logic                speed_ok;
      logic [SLOT_W-1:0]   restore_slot;
      logic [LEAN_W-1:0]   restore_value;
   } req_type;

   typedef struct packed {
      logic [LEAN_W-1:0]  lean_left;
      logic [LEAN_W-1:0]  lean_right;
      logic [ACCEL_W-1:0] accel;
      logic [ACCEL_W-1:0] brake;
      logic [SPEED_W-1:0] speed;
   } rec_set_type;

   typedef struct packed {
      rec_set_type ride;
      rec_set_type all;
      logic        unsaved;
      logic        raised;
   } rsp_type;

   function automatic logic lift_ok(input logic [CAND_W-1:0] cand,
                                    input logic [CAND_W-1:0] lo,
                                    input logic [CAND_W-1:0] hi,
                                    input logic [CAND_W-1:0] held);
      return (cand >= lo) && (cand <= hi) && (cand > held);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/rprt_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ride peak record tracker configuration registers
// Credible window limits, written through a plain write port.
// ----------------------------------------------------------------------------
module rprt_cfg_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [rprt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [rprt_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rprt_pkg::cfg_type                        cfg
);

   rprt_pkg::cfg_type cfg_ff;
   rprt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            rprt_pkg::REG_LEAN_MIN:  cfg_in.lean_min  = csr_wdata[rprt_pkg::LEAN_W-1:0];
            rprt_pkg::REG_LEAN_MAX:  cfg_in.lean_max  = csr_wdata[rprt_pkg::LEAN_W-1:0];
            rprt_pkg::REG_ACCEL_MIN: cfg_in.accel_min = csr_wdata[rprt_pkg::ACCEL_W-1:0];
            rprt_pkg::REG_ACCEL_MAX: cfg_in.accel_max = csr_wdata[rprt_pkg::ACCEL_W-1:0];
            rprt_pkg::REG_SPEED_MIN: cfg_in.speed_min = csr_wdata[rprt_pkg::SPEED_W-1:0];
            rprt_pkg::REG_SPEED_MAX: cfg_in.speed_max = csr_wdata[rprt_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lean_min  <= '0;
         cfg_ff.lean_max  <= rprt_pkg::LEAN_MAX_RESET;
         cfg_ff.accel_min <= '0;
         cfg_ff.accel_max <= rprt_pkg::ACCEL_MAX_RESET;
         cfg_ff.speed_min <= '0;
         cfg_ff.speed_max <= rprt_pkg::SPEED_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== rtl/rprt_record_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ride peak record tracker record core
// Holds the session and all-time records and the dirty flag, and forms the
// result of each accepted beat combinationally.
// ----------------------------------------------------------------------------
module rprt_record_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire rprt_pkg::req_type req,
   input  wire rprt_pkg::cfg_type cfg,
   output rprt_pkg::rsp_type      result
);

   rprt_pkg::rec_set_type ride_ff, ride_in;
   rprt_pkg::rec_set_type all_ff, all_in;
   logic                  dirty_ff, dirty_in;

   logic                            roll_neg;
   logic [rprt_pkg::CAND_W-1:0]     lean_cand;
   logic                            accel_sel;
   logic [rprt_pkg::CAND_W-1:0]     g_cand;
   logic [rprt_pkg::CAND_W-1:0]     spd_cand;
   logic [rprt_pkg::CAND_W-1:0]     lean_lo, lean_hi, acc_lo, acc_hi, spd_lo, spd_hi;
   logic                            is_orient, is_speed;
   logic                            r_left, r_right, r_accel, r_brake, r_speed;
   logic                            a_left, a_right, a_accel, a_brake, a_speed;
   logic                            changed;
   logic                            slot_ok, slot_all;
   logic [rprt_pkg::KIND_W-1:0]     kind;
   logic [rprt_pkg::SLOT_W-1:0]     kind_wide;
   logic [rprt_pkg::LEAN_W-1:0]     sat_lean;
   logic [rprt_pkg::ACCEL_W-1:0]    sat_accel;
   logic [rprt_pkg::SPEED_W-1:0]    sat_speed;
   rprt_pkg::rec_set_type           restored;

   always_comb begin
      roll_neg  = req.roll_angle[15];
      lean_cand = roll_neg ? (17'h10000 - 17'({1'b0, req.roll_angle}))
                           : 17'({1'b0, req.roll_angle});
      accel_sel = (req.longitudinal_g != '0) && !req.longitudinal_g[14];
      g_cand    = accel_sel ? 17'({1'b0, req.longitudinal_g})
                            : 17'(16'h8000 - 16'({1'b0, req.longitudinal_g}));
      spd_cand  = 17'(req.speed_value);
      lean_lo = 17'(cfg.lean_min);
      lean_hi = 17'(cfg.lean_max);
      acc_lo  = 17'(cfg.accel_min);
      acc_hi  = 17'(cfg.accel_max);
      spd_lo  = 17'(cfg.speed_min);
      spd_hi  = 17'(cfg.speed_max);

      is_orient = (rprt_pkg::cmd_type'(req.command) == rprt_pkg::CMD_ORIENT);
      is_speed  = (rprt_pkg::cmd_type'(req.command) == rprt_pkg::CMD_SPEED) && req.speed_ok;

      r_left  = is_orient && roll_neg &&
                rprt_pkg::lift_ok(lean_cand, lean_lo, lean_hi, 17'(ride_ff.lean_left));
      r_right = is_orient && !roll_neg &&
                rprt_pkg::lift_ok(lean_cand, lean_lo, lean_hi, 17'(ride_ff.lean_right));
      r_accel = is_orient && accel_sel &&
                rprt_pkg::lift_ok(g_cand, acc_lo, acc_hi, 17'(ride_ff.accel));
      r_brake = is_orient && !accel_sel &&
                rprt_pkg::lift_ok(g_cand, acc_lo, acc_hi, 17'(ride_ff.brake));
      r_speed = is_speed &&
                rprt_pkg::lift_ok(spd_cand, spd_lo, spd_hi, 17'(ride_ff.speed));
      a_left  = is_orient && roll_neg &&
                rprt_pkg::lift_ok(lean_cand, lean_lo, lean_hi, 17'(all_ff.lean_left));
      a_right = is_orient && !roll_neg &&
                rprt_pkg::lift_ok(lean_cand, lean_lo, lean_hi, 17'(all_ff.lean_right));
      a_accel = is_orient && accel_sel &&
                rprt_pkg::lift_ok(g_cand, acc_lo, acc_hi, 17'(all_ff.accel));
      a_brake = is_orient && !accel_sel &&
                rprt_pkg::lift_ok(g_cand, acc_lo, acc_hi, 17'(all_ff.brake));
      a_speed = is_speed &&
                rprt_pkg::lift_ok(spd_cand, spd_lo, spd_hi, 17'(all_ff.speed));
      changed = r_left || r_right || r_accel || r_brake || r_speed ||
                a_left || a_right || a_accel || a_brake || a_speed;
   end

   always_comb begin
      slot_ok   = (req.restore_slot <= rprt_pkg::LAST_SLOT);
      slot_all  = (req.restore_slot < rprt_pkg::NUM_KINDS);
      kind_wide = slot_all ? req.restore_slot : (req.restore_slot - rprt_pkg::NUM_KINDS);
      kind      = kind_wide[rprt_pkg::KIND_W-1:0];
      sat_lean  = (req.restore_value > rprt_pkg::LEAN_HIGH) ? rprt_pkg::LEAN_HIGH
                                                            : req.restore_value;
      sat_accel = (req.restore_value > 15'(rprt_pkg::ACCEL_HIGH)) ? rprt_pkg::ACCEL_HIGH
                  : req.restore_value[rprt_pkg::ACCEL_W-1:0];
      sat_speed = (req.restore_value > 15'(rprt_pkg::SPEED_HIGH)) ? rprt_pkg::SPEED_HIGH
                  : req.restore_value[rprt_pkg::SPEED_W-1:0];
      restored = slot_all ? all_ff : ride_ff;
      case (kind)
         rprt_pkg::KIND_LEFT:  restored.lean_left  = sat_lean;
         rprt_pkg::KIND_RIGHT: restored.lean_right = sat_lean;
         rprt_pkg::KIND_ACCEL: restored.accel      = sat_accel;
         rprt_pkg::KIND_BRAKE: restored.brake      = sat_accel;
         rprt_pkg::KIND_SPEED: restored.speed      = sat_speed;
         default: ;
      endcase
   end

   always_comb begin
      ride_in  = ride_ff;
      all_in   = all_ff;
      dirty_in = dirty_ff;
      case (rprt_pkg::cmd_type'(req.command))
         rprt_pkg::CMD_ORIENT, rprt_pkg::CMD_SPEED: begin
            if (r_left)  ride_in.lean_left  = lean_cand[rprt_pkg::LEAN_W-1:0];
            if (r_right) ride_in.lean_right = lean_cand[rprt_pkg::LEAN_W-1:0];
            if (r_accel) ride_in.accel      = g_cand[rprt_pkg::ACCEL_W-1:0];
            if (r_brake) ride_in.brake      = g_cand[rprt_pkg::ACCEL_W-1:0];
            if (r_speed) ride_in.speed      = spd_cand[rprt_pkg::SPEED_W-1:0];
            if (a_left)  all_in.lean_left   = lean_cand[rprt_pkg::LEAN_W-1:0];
            if (a_right) all_in.lean_right  = lean_cand[rprt_pkg::LEAN_W-1:0];
            if (a_accel) all_in.accel       = g_cand[rprt_pkg::ACCEL_W-1:0];
            if (a_brake) all_in.brake       = g_cand[rprt_pkg::ACCEL_W-1:0];
            if (a_speed) all_in.speed       = spd_cand[rprt_pkg::SPEED_W-1:0];
            if (changed) dirty_in = 1'b1;
         end
         rprt_pkg::CMD_NEW_RIDE: begin
            ride_in  = '0;
            dirty_in = 1'b1;
         end
         rprt_pkg::CMD_RESET_ALL: begin
            ride_in  = '0;
            all_in   = '0;
            dirty_in = 1'b1;
         end
         rprt_pkg::CMD_RESTORE: begin
            if (slot_ok) begin
               if (slot_all) begin
                  all_in = restored;
               end else begin
                  ride_in = restored;
               end
               dirty_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ride_ff  <= '0;
         all_ff   <= '0;
         dirty_ff <= 1'b0;
      end else if (accept) begin
         ride_ff  <= ride_in;
         all_ff   <= all_in;
         dirty_ff <= dirty_in;
      end
   end

   always_comb begin
      result.ride    = ride_in;
      result.all     = all_in;
      result.unsaved = dirty_in;
      result.raised  = changed;
   end

   a_raise_sets_dirty: assert property (@(posedge clock) disable iff (reset)
      accept && changed |=> dirty_ff)
      else $error("raised record did not set the dirty flag");

   a_reset_all_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req.command == rprt_pkg::CMD_RESET_ALL)
      |=> (ride_ff == '0) && (all_ff == '0) && dirty_ff)
      else $error("reset-all left a record or the dirty flag wrong");

   a_restore_clean: assert property (@(posedge clock) disable iff (reset)
      accept && (req.command == rprt_pkg::CMD_RESTORE) &&
      (req.restore_slot <= rprt_pkg::LAST_SLOT) |=> !dirty_ff)
      else $error("restore did not clear the dirty flag");

endmodule
`default_nettype wire

// ===== rtl/rprt_out_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ride peak record tracker result buffer
// Output register with a skid stage, so a beat is taken while a result waits.
// ----------------------------------------------------------------------------
module rprt_out_buffer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_stall,
   input  wire rprt_pkg::rsp_type in_data,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output rprt_pkg::rsp_type      out_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   rprt_pkg::rsp_type out_data_ff, out_data_in;
   rprt_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              in_take, out_take;

   always_comb begin
      in_take  = in_valid && !skid_valid_ff;
      out_take = out_valid_ff && !out_stall;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_take) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage full while output register empty");

   a_stalled_beat_to_skid: assert property (@(posedge clock) disable iff (reset)
      in_take && out_valid_ff && out_stall |=> skid_valid_ff && (skid_data_ff == $past(in_data)))
      else $error("beat taken under stall was not held in the skid stage");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> out_valid_ff && !skid_valid_ff &&
      (out_data_ff == $past(skid_data_ff)))
      else $error("skid stage did not move to the output register");

endmodule
`default_nettype wire

// ===== rtl/ride_peak_record_tracker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ride peak record tracker
// Peak-hold records of lean, acceleration, braking and speed for the current
// session and for all time, with a dirty flag for the saved copy.
//
//   Channel  Direction  Handshake             Contents
//   req_*    in         req_valid/req_stall   command and sample fields
//   rsp_*    out        rsp_valid/rsp_stall   all ten records, unsaved, raised
//   csr_*    in         csr_wr_en             window limits, index 0 to 5
//
// One beat is accepted every cycle while req_stall is low; its result is
// registered in the result buffer. Record registers update by compare-and-hold.
// Reset is synchronous: records, dirty flag and buffer clear, limits reload.
// A two-entry result buffer absorbs one beat under rsp_stall; req_stall rises
// only while its skid stage is occupied.
// ----------------------------------------------------------------------------
module ride_peak_record_tracker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [2:0]                       req_command,
   input  wire logic signed [15:0]               req_roll_angle,
   input  wire logic signed [14:0]               req_longitudinal_g,
   input  wire logic [rprt_pkg::SPEED_W-1:0]     req_speed_value,
   input  wire logic                             req_speed_ok,
   input  wire logic [rprt_pkg::SLOT_W-1:0]      req_restore_slot,
   input  wire logic [rprt_pkg::LEAN_W-1:0]      req_restore_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [rprt_pkg::LEAN_W-1:0]           rsp_ride_lean_left,
   output logic [rprt_pkg::LEAN_W-1:0]           rsp_ride_lean_right,
   output logic [rprt_pkg::ACCEL_W-1:0]          rsp_ride_accel,
   output logic [rprt_pkg::ACCEL_W-1:0]          rsp_ride_brake,
   output logic [rprt_pkg::SPEED_W-1:0]          rsp_ride_speed,
   output logic [rprt_pkg::LEAN_W-1:0]           rsp_all_lean_left,
   output logic [rprt_pkg::LEAN_W-1:0]           rsp_all_lean_right,
   output logic [rprt_pkg::ACCEL_W-1:0]          rsp_all_accel,
   output logic [rprt_pkg::ACCEL_W-1:0]          rsp_all_brake,
   output logic [rprt_pkg::SPEED_W-1:0]          rsp_all_speed,
   output logic                                  rsp_unsaved,
   output logic                                  rsp_raised,
   input  wire logic                             csr_wr_en,
   input  wire logic [rprt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rprt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   rprt_pkg::cfg_type cfg;
   rprt_pkg::req_type req;
   rprt_pkg::rsp_type result;
   rprt_pkg::rsp_type rsp;
   logic              accept;

   always_comb begin
      req.command        = req_command;
      req.roll_angle     = req_roll_angle;
      req.longitudinal_g = req_longitudinal_g;
      req.speed_value    = req_speed_value;
      req.speed_ok       = req_speed_ok;
      req.restore_slot   = req_restore_slot;
      req.restore_value  = req_restore_value;
   end

   assign accept = req_valid && !req_stall;

   rprt_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rprt_record_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req),
      .cfg    (cfg),
      .result (result)
   );

   rprt_out_buffer u_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp)
   );

   always_comb begin
      rsp_ride_lean_left  = rsp.ride.lean_left;
      rsp_ride_lean_right = rsp.ride.lean_right;
      rsp_ride_accel      = rsp.ride.accel;
      rsp_ride_brake      = rsp.ride.brake;
      rsp_ride_speed      = rsp.ride.speed;
      rsp_all_lean_left   = rsp.all.lean_left;
      rsp_all_lean_right  = rsp.all.lean_right;
      rsp_all_accel       = rsp.all.accel;
      rsp_all_brake       = rsp.all.brake;
      rsp_all_speed       = rsp.all.speed;
      rsp_unsaved         = rsp.unsaved;
      rsp_raised          = rsp.raised;
   end

endmodule
`default_nettype wire
